// File: hdl/tazm_pkg.sv
// Package for the tile and z-scan address mapper.
// Holds the beat structs, function codes and configuration register indexes.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package tazm_pkg;

  localparam logic [1:0] FUNC_LOAD_COL = 2'd0;
  localparam logic [1:0] FUNC_LOAD_ROW = 2'd1;
  localparam logic [1:0] FUNC_MAP_CTB  = 2'd2;
  localparam logic [1:0] FUNC_MAP_TB   = 2'd3;

  localparam logic [2:0] CFG_PIC_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_PIC_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_TILE_COLS  = 3'd2;
  localparam logic [2:0] CFG_TILE_ROWS  = 3'd3;
  localparam logic [2:0] CFG_UNIFORM    = 3'd4;
  localparam logic [2:0] CFG_LOG2_CTB   = 3'd5;
  localparam logic [2:0] CFG_LOG2_MINTB = 3'd6;

  typedef struct packed {
    logic [1:0]  func;
    logic [4:0]  entry_index;
    logic [10:0] entry_size;
    logic [19:0] ctb_raster_addr;
    logic [13:0] tb_x;
    logic [13:0] tb_y;
  } in_beat_t;

  typedef struct packed {
    logic [19:0] tile_scan_addr;
    logic [8:0]  tile_index;
    logic [27:0] zscan_addr;
    logic        out_of_range;
  } out_beat_t;

endpackage
`default_nettype wire

// File: hdl/tile_and_zscan_address_map.sv
// Tile and z-scan address mapper: top level with configuration registers and sequencer.
// Depends on tazm_pkg and tazm_ram.
// Load beats write the addressed table entry. A ctb map beat runs three divisions on the
// shared bit-serial divider (two for a tb map), a walk over the clamped tile columns and
// rows with one read port per table, then the multiply steps and the output state.
// One map at a time. Out-of-picture requests answer from idle. Synchronous active-low reset
// clears control state and sets the registers to their defaults; the tables stay undefined.
`timescale 1ns / 1ps
`default_nettype none
module tile_and_zscan_address_map
  import tazm_pkg::*;
#(
  parameter int MAX_TILE_COLS = 20,
  parameter int MAX_TILE_ROWS = 22,
  parameter int MAX_PIC_CTBS  = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_beat_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_beat_t        out_data,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [10:0] cfg_wdata
);

  localparam int TMAX = (MAX_TILE_COLS > MAX_TILE_ROWS) ? MAX_TILE_COLS : MAX_TILE_ROWS;
  localparam int CW0  = $clog2(TMAX + 1);
  localparam int CW   = (CW0 > 5) ? CW0 : 5;
  localparam int CAW  = (MAX_TILE_COLS > 1) ? $clog2(MAX_TILE_COLS) : 1;
  localparam int RAW  = (MAX_TILE_ROWS > 1) ? $clog2(MAX_TILE_ROWS) : 1;
  localparam int PCW  = $clog2(MAX_PIC_CTBS + 1);
  localparam int PEW  = (PCW > 11) ? PCW : 11;
  localparam int DIV_STEPS = 20;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_WADDR, S_WSTEP, S_M0, S_M1, S_M2, S_M3, S_FIN
  } state_t;

  typedef enum logic [1:0] {
    PH_ADDR, PH_COLS, PH_ROWS
  } phase_t;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;

  logic [10:0] pw_r, ph_r;
  logic [4:0]  tc_r, tr_r;
  logic        uni_r;
  logic [2:0]  lctb_r, lmin_r;

  logic          is_tb_r, is_tb_nxt;
  logic [10:0]   cx_r, cx_nxt, cy_r, cy_nxt;
  logic [7:0]    zlow_r, zlow_nxt;
  logic [4:0]    dcnt_r, dcnt_nxt;
  logic [19:0]   dq_r, dq_nxt;
  logic [10:0]   drem_r, drem_nxt, dd_r, dd_nxt;
  logic [10:0]   qc_r, qc_nxt, qr_r, qr_nxt;
  logic [CW-1:0] rc_r, rc_nxt, rr_r, rr_nxt;
  logic          wrow_r, wrow_nxt;
  logic [CW-1:0] wi_r, wi_nxt, wr_r, wr_nxt;
  logic [10:0]   wbd_r, wbd_nxt, wq_r, wq_nxt;
  logic [10:0]   clo_r, clo_nxt, chi_r, chi_nxt, rlo_r, rlo_nxt, rhi_r, rhi_nxt;
  logic [CW-1:0] tx_r, tx_nxt, ty_r, ty_nxt;
  logic [21:0]   acc_r, acc_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_beat_t     out_data_r, out_data_nxt;

  logic [10:0]   wc, hc;
  logic [CW-1:0] colsc, rowsc, tc_ext, tr_ext;
  logic [2:0]    lctbc, lminc, diff;
  logic [21:0]   wh;
  logic [14:0]   x_lim, y_lim;
  logic [7:0]    zlow_c;
  logic          out_free, accept;

  logic [11:0]   dshift;
  logic          dge;
  logic [10:0]   drem_s;
  logic [19:0]   dq_s;

  logic [10:0]   col_rdata, row_rdata;
  logic          col_we, row_we;

  logic [CW-1:0] w_n, w_rs, w_last_i;
  logic [10:0]   w_pic, w_qs, w_pos, w_tab, w_qn, w_next;
  logic [CW:0]   w_rsum;
  logic [11:0]   w_sum;
  logic          w_last;

  logic [10:0]   mul_a, mul_b;
  logic [21:0]   mul_p;
  logic [2*CW-1:0] tidx;
  logic [27:0]   zs;

  assign tc_ext = CW'(tc_r);
  assign tr_ext = CW'(tr_r);
  assign colsc = (tc_ext == '0) ? CW'(1) :
                 (tc_ext > CW'(MAX_TILE_COLS)) ? CW'(MAX_TILE_COLS) : tc_ext;
  assign rowsc = (tr_ext == '0) ? CW'(1) :
                 (tr_ext > CW'(MAX_TILE_ROWS)) ? CW'(MAX_TILE_ROWS) : tr_ext;
  assign wc = (pw_r == '0) ? 11'd1 :
              (PEW'(pw_r) > PEW'(MAX_PIC_CTBS)) ? 11'(MAX_PIC_CTBS) : pw_r;
  assign hc = (ph_r == '0) ? 11'd1 :
              (PEW'(ph_r) > PEW'(MAX_PIC_CTBS)) ? 11'(MAX_PIC_CTBS) : ph_r;
  assign lctbc = (lctb_r < 3'd4) ? 3'd4 : (lctb_r > 3'd6) ? 3'd6 : lctb_r;
  assign lminc = (lmin_r < 3'd2) ? 3'd2 : (lmin_r > lctbc) ? lctbc : lmin_r;
  assign diff  = lctbc - lminc;
  assign wh    = 22'(wc) * 22'(hc);
  assign x_lim = 15'(wc) << diff;
  assign y_lim = 15'(hc) << diff;

  always_comb begin
    zlow_c = '0;
    for (int i = 0; i < 4; i++) begin
      if (3'(i) < diff) begin
        zlow_c[2*i]   = in_data.tb_x[i];
        zlow_c[2*i+1] = in_data.tb_y[i];
      end
    end
  end

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign col_we = accept && (in_data.func == FUNC_LOAD_COL) &&
                  (CW'(in_data.entry_index) < CW'(MAX_TILE_COLS));
  assign row_we = accept && (in_data.func == FUNC_LOAD_ROW) &&
                  (CW'(in_data.entry_index) < CW'(MAX_TILE_ROWS));

  tazm_ram #(.WIDTH(11), .DEPTH(MAX_TILE_COLS)) u_col_ram (
    .clk   (clk),
    .we    (col_we),
    .waddr (CAW'(in_data.entry_index)),
    .wdata (in_data.entry_size),
    .raddr (CAW'(wi_r)),
    .rdata (col_rdata)
  );

  tazm_ram #(.WIDTH(11), .DEPTH(MAX_TILE_ROWS)) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (RAW'(in_data.entry_index)),
    .wdata (in_data.entry_size),
    .raddr (RAW'(wi_r)),
    .rdata (row_rdata)
  );

  assign dshift = {drem_r, dq_r[19]};
  assign dge    = dshift >= {1'b0, dd_r};
  assign drem_s = dge ? 11'(dshift - {1'b0, dd_r}) : dshift[10:0];
  assign dq_s   = {dq_r[18:0], dge};

  assign w_n    = wrow_r ? rowsc : colsc;
  assign w_pic  = wrow_r ? hc : wc;
  assign w_qs   = wrow_r ? qr_r : qc_r;
  assign w_rs   = wrow_r ? rr_r : rc_r;
  assign w_pos  = wrow_r ? cy_r : cx_r;
  assign w_tab  = wrow_r ? row_rdata : col_rdata;
  assign w_last_i = wi_r + CW'(1);
  assign w_last = (w_last_i == w_n);

  always_comb begin
    w_qn   = wq_r + w_qs;
    w_rsum = (CW+1)'(wr_r) + (CW+1)'(w_rs);
    if (w_rsum >= (CW+1)'(w_n)) begin
      w_rsum = w_rsum - (CW+1)'(w_n);
      w_qn   = w_qn + 11'd1;
    end
    w_sum = 12'(wbd_r) + 12'(w_tab);
    if (uni_r) begin
      w_next = w_qn;
    end else if (w_last) begin
      w_next = w_pic;
    end else if (w_sum > 12'(w_pic)) begin
      w_next = w_pic;
    end else begin
      w_next = w_sum[10:0];
    end
  end

  always_comb begin
    case (state_r)
      S_M0: begin
        mul_a = wc;
        mul_b = rlo_r;
      end
      S_M1: begin
        mul_a = rhi_r - rlo_r;
        mul_b = clo_r;
      end
      default: begin
        mul_a = cy_r - rlo_r;
        mul_b = chi_r - clo_r;
      end
    endcase
  end
  assign mul_p = 22'(mul_a) * 22'(mul_b);
  assign tidx  = (2*CW)'(ty_r) * (2*CW)'(colsc) + (2*CW)'(tx_r);
  assign zs    = 28'(zlow_r) + (28'(acc_r) << {diff, 1'b0});

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    is_tb_nxt = is_tb_r;
    cx_nxt = cx_r;
    cy_nxt = cy_r;
    zlow_nxt = zlow_r;
    dcnt_nxt = dcnt_r;
    dq_nxt = dq_r;
    drem_nxt = drem_r;
    dd_nxt = dd_r;
    qc_nxt = qc_r;
    rc_nxt = rc_r;
    qr_nxt = qr_r;
    rr_nxt = rr_r;
    wrow_nxt = wrow_r;
    wi_nxt = wi_r;
    wr_nxt = wr_r;
    wbd_nxt = wbd_r;
    wq_nxt = wq_r;
    clo_nxt = clo_r;
    chi_nxt = chi_r;
    rlo_nxt = rlo_r;
    rhi_nxt = rhi_r;
    tx_nxt = tx_r;
    ty_nxt = ty_r;
    acc_nxt = acc_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt = out_data_r;

    case (state_r)
      S_IDLE: begin
        if (accept && in_data.func == FUNC_MAP_CTB) begin
          is_tb_nxt = 1'b0;
          zlow_nxt = '0;
          if (22'(in_data.ctb_raster_addr) >= wh) begin
            out_valid_nxt = 1'b1;
            out_data_nxt = '0;
            out_data_nxt.out_of_range = 1'b1;
          end else begin
            phase_nxt = PH_ADDR;
            dq_nxt = in_data.ctb_raster_addr;
            drem_nxt = '0;
            dd_nxt = wc;
            dcnt_nxt = '0;
            state_nxt = S_DIV;
          end
        end else if (accept && in_data.func == FUNC_MAP_TB) begin
          is_tb_nxt = 1'b1;
          zlow_nxt = zlow_c;
          cx_nxt = 11'(in_data.tb_x >> diff);
          cy_nxt = 11'(in_data.tb_y >> diff);
          if (15'(in_data.tb_x) >= x_lim || 15'(in_data.tb_y) >= y_lim) begin
            out_valid_nxt = 1'b1;
            out_data_nxt = '0;
            out_data_nxt.out_of_range = 1'b1;
          end else begin
            phase_nxt = PH_COLS;
            dq_nxt = 20'(wc);
            drem_nxt = '0;
            dd_nxt = 11'(colsc);
            dcnt_nxt = '0;
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        dq_nxt = dq_s;
        drem_nxt = drem_s;
        dcnt_nxt = dcnt_r + 5'd1;
        if (dcnt_r == 5'(DIV_STEPS - 1)) begin
          dcnt_nxt = '0;
          drem_nxt = '0;
          case (phase_r)
            PH_ADDR: begin
              cx_nxt = drem_s;
              cy_nxt = dq_s[10:0];
              phase_nxt = PH_COLS;
              dq_nxt = 20'(wc);
              dd_nxt = 11'(colsc);
            end
            PH_COLS: begin
              qc_nxt = dq_s[10:0];
              rc_nxt = drem_s[CW-1:0];
              phase_nxt = PH_ROWS;
              dq_nxt = 20'(hc);
              dd_nxt = 11'(rowsc);
            end
            default: begin
              qr_nxt = dq_s[10:0];
              rr_nxt = drem_s[CW-1:0];
              wrow_nxt = 1'b0;
              wi_nxt = '0;
              wr_nxt = '0;
              wbd_nxt = '0;
              wq_nxt = '0;
              state_nxt = S_WADDR;
            end
          endcase
        end
      end
      S_WADDR: begin
        state_nxt = S_WSTEP;
      end
      S_WSTEP: begin
        if (w_pos >= wbd_r) begin
          if (wrow_r) begin
            rlo_nxt = wbd_r;
            rhi_nxt = w_next;
            ty_nxt = wi_r;
          end else begin
            clo_nxt = wbd_r;
            chi_nxt = w_next;
            tx_nxt = wi_r;
          end
        end
        wbd_nxt = w_next;
        wq_nxt = w_qn;
        wr_nxt = w_rsum[CW-1:0];
        wi_nxt = w_last_i;
        state_nxt = S_WADDR;
        if (w_last) begin
          wi_nxt = '0;
          wbd_nxt = '0;
          wq_nxt = '0;
          wr_nxt = '0;
          if (wrow_r) begin
            state_nxt = S_M0;
          end else begin
            wrow_nxt = 1'b1;
          end
        end
      end
      S_M0: begin
        acc_nxt = mul_p;
        state_nxt = S_M1;
      end
      S_M1: begin
        acc_nxt = acc_r + mul_p;
        state_nxt = S_M2;
      end
      S_M2: begin
        acc_nxt = acc_r + mul_p;
        state_nxt = S_M3;
      end
      S_M3: begin
        acc_nxt = acc_r + 22'(cx_r - clo_r);
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt = '0;
          if (is_tb_r) begin
            out_data_nxt.zscan_addr = zs;
          end else begin
            out_data_nxt.tile_scan_addr = acc_r[19:0];
            out_data_nxt.tile_index = 9'(tidx);
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_ADDR;
      out_valid_r <= 1'b0;
      pw_r <= 11'd1;
      ph_r <= 11'd1;
      tc_r <= 5'd1;
      tr_r <= 5'd1;
      uni_r <= 1'b1;
      lctb_r <= 3'd4;
      lmin_r <= 3'd2;
      dcnt_r <= '0;
      wrow_r <= 1'b0;
      wi_r <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      out_valid_r <= out_valid_nxt;
      dcnt_r <= dcnt_nxt;
      wrow_r <= wrow_nxt;
      wi_r <= wi_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_PIC_WIDTH:  pw_r <= cfg_wdata;
          CFG_PIC_HEIGHT: ph_r <= cfg_wdata;
          CFG_TILE_COLS:  tc_r <= cfg_wdata[4:0];
          CFG_TILE_ROWS:  tr_r <= cfg_wdata[4:0];
          CFG_UNIFORM:    uni_r <= cfg_wdata[0];
          CFG_LOG2_CTB:   lctb_r <= cfg_wdata[2:0];
          CFG_LOG2_MINTB: lmin_r <= cfg_wdata[2:0];
          default: begin
          end
        endcase
      end
    end
    is_tb_r <= is_tb_nxt;
    cx_r <= cx_nxt;
    cy_r <= cy_nxt;
    zlow_r <= zlow_nxt;
    dq_r <= dq_nxt;
    drem_r <= drem_nxt;
    dd_r <= dd_nxt;
    qc_r <= qc_nxt;
    rc_r <= rc_nxt;
    qr_r <= qr_nxt;
    rr_r <= rr_nxt;
    wr_r <= wr_nxt;
    wbd_r <= wbd_nxt;
    wq_r <= wq_nxt;
    clo_r <= clo_nxt;
    chi_r <= chi_nxt;
    rlo_r <= rlo_nxt;
    rhi_r <= rhi_nxt;
    tx_r <= tx_nxt;
    ty_r <= ty_nxt;
    acc_r <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
`default_nettype wire

// File: hdl/tazm_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Used for the tile column width and row height tables. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module tazm_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 20
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire
